### rtl/core/fqmr_pkg.sv
`timescale 1ns / 1ps
package fqmr_pkg;
   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_PEEK    = 2'd2,
      OP_MOVE    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_FILL,
      ST_DONE
   } state_type;

   // control from sequencer to every cell
   typedef struct packed {
      logic        shift;
      logic [31:0] key;
   } cell_ctrl_type;
endpackage

### rtl/core/fifo_queue_with_move_to_rear.sv
`timescale 1ns / 1ps
// channel | direction | tdata fields (low bit up)                          | tuser
// req     | in        | opcode[1:0], data_value[33:2], pad to 40           | -
// rsp     | out       | result_value, match_count, is_empty, occupancy,   | -
//         |           | overflow, pad to 48                                |
// enqueue, dequeue, peek and move on an empty queue: result offered the cycle after accept
// move-to-rear takes one rotation step per entry,
// kept entries cycle to the back of a shrinking window while matches drop out,
// then a fill step writes the key into the tail
// reset clears count and sequencer; cell contents are undefined until written
// a stalled result holds the block; the next item is taken once it is delivered
module fifo_queue_with_move_to_rear
   import fqmr_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // opcode, data_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // result_value, match_count, is_empty, occupancy, overflow
);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   // cell 0 is the front; the queue sits in cells 0..count-1
   logic [31:0] cell_value [DEPTH];
   logic [DEPTH-1:0] cell_load;
   logic [DEPTH-1:0] cell_fill;
   logic [31:0] load_value;
   logic cell_shift;
   cell_ctrl_type ctrl;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] step_ff, step_in;
   logic [CW-1:0] match_ff, match_in;
   logic [CW-1:0] kept_ff, kept_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] result_ff, result_in;
   logic over_ff, over_in;
   logic [CW-1:0] window;

   opcode_type op;
   logic [31:0] word;
   logic accept;

   assign op = opcode_type'(req_tdata[1:0]);
   assign word = req_tdata[33:2];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;

   assign ctrl = '{shift: cell_shift, key: key_ff};
   // unprocessed and kept entries sit in cells 0..window-1
   assign window = count_ff - match_ff;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         fqmr_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .load       (cell_load[g]),
            .fill       (cell_fill[g]),
            .load_value (load_value),
            .prev_value (cell_value[(g + 1) % DEPTH]),
            .value      (cell_value[g])
         );
      end
   endgenerate

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op == OP_MOVE && count_ff != '0) begin
                  state_in = ST_ROTATE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ROTATE: begin
            if (step_ff == count_ff - CW'(1)) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and cell control
   always_comb begin
      count_in   = count_ff;
      step_in    = step_ff;
      match_in   = match_ff;
      kept_in    = kept_ff;
      key_in     = key_ff;
      result_in  = result_ff;
      over_in    = over_ff;
      cell_load  = '0;
      load_value = word;
      cell_shift = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               result_in = '0;
               match_in  = '0;
               over_in   = 1'b0;
               step_in   = '0;
               kept_in   = '0;
               key_in    = word;
               case (op)
                  OP_ENQUEUE: begin
                     if (count_ff == CW'(DEPTH)) begin
                        over_in = 1'b1;
                     end else begin
                        cell_load[count_ff[IW-1:0]] = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_DEQUEUE: begin
                     if (count_ff != '0) begin
                        result_in  = cell_value[0];
                        cell_shift = 1'b1;
                        count_in   = count_ff - CW'(1);
                     end
                  end
                  OP_PEEK: begin
                     if (count_ff != '0) begin
                        result_in = cell_value[0];
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ROTATE: begin
            // front leaves; a kept entry returns at the window's end, a match drops out
            cell_shift = 1'b1;
            step_in = step_ff + CW'(1);
            if (cell_value[0] == key_ff) begin
               match_in = match_ff + CW'(1);
            end else begin
               kept_in = kept_ff + CW'(1);
               cell_load[IW'(window - CW'(1))] = 1'b1;
               load_value = cell_value[0];
            end
         end
         default: ;
      endcase
   end

   // tail refill with key after rotation: cells kept..count-1
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_fill[i] = (state_ff == ST_FILL) && (CW'(i) >= kept_ff) && (CW'(i) < count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      step_ff   <= step_in;
      match_ff  <= match_in;
      kept_ff   <= kept_in;
      key_ff    <= key_in;
      result_ff <= result_in;
      over_ff   <= over_in;
   end

   assign rsp_tvalid = (state_ff == ST_DONE);
   assign rsp_tdata  = {4'b0, over_ff, 5'(count_ff), (count_ff == '0),
                        5'(match_ff), result_ff};
endmodule

### rtl/core/fqmr_cell.sv
`timescale 1ns / 1ps
module fqmr_cell
   import fqmr_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          load,
   input  logic          fill,
   input  logic [31:0]   load_value,
   input  logic [31:0]   prev_value,
   output logic [31:0]   value
);
   logic [31:0] value_ff;
   logic [31:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (load) begin
         value_in = load_value;
      end else if (fill) begin
         value_in = ctrl.key;
      end else if (ctrl.shift) begin
         value_in = prev_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule

### rtl/core/fqmr_checker.sv
`timescale 1ns / 1ps
module fqmr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("item taken while result pending");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken before previous result");
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[37] == (rsp_tdata[42:38] == 5'd0))
      else $error("empty flag disagrees with occupancy");
   a_match_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[36:32] <= rsp_tdata[42:38])
      else $error("match count above occupancy");
endmodule

bind fifo_queue_with_move_to_rear fqmr_checker u_fqmr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
